// ===== rtl/core/lru_kv_pkg.sv =====
// package for the lru key/value cache: opcodes, default sizes, register reset
// no dependencies; used by lru_key_value_cache
`default_nettype none

package lru_kv_pkg;

  // default sizes handed to the top level parameters
  localparam int unsigned Capacity   = 16;
  localparam int unsigned KeyWidth   = 32;
  localparam int unsigned ValueWidth = 32;

  // fixed widths of the configuration register and the count output
  localparam int unsigned CfgWidth   = 5;
  localparam int unsigned CountWidth = 5;

  localparam logic [CfgWidth-1:0] MaxEntriesReset = CfgWidth'(16);

  // request opcodes
  typedef enum logic [1:0] {
    OP_FIND   = 2'd0,
    OP_INSERT = 2'd1,
    OP_PEEK   = 2'd2,
    OP_ACCESS = 2'd3
  } op_e;

endpackage

`default_nettype wire

// ===== rtl/core/lru_key_value_cache.sv =====
// fully associative key/value cache with least-recently-used replacement
// depends on lru_kv_pkg for opcodes, default sizes and the register reset
//
//  channel   signals                                        direction
//  request   in_valid_i/in_ready_o, opcode, req_key/value   in
//  result    out_valid_o/out_ready_i, hit .. entry_count    out
//  config    max_entries_we_i, max_entries_i                in, no wait
//
// a request beat is captured in the request register, then key compare and age
// update write the slots and the result register, which holds the result. one
// request per cycle while the result is not stalled, as the compare runs in
// parallel over all slots. a stalled result holds the compute stage; the request
// register still takes one more beat if it is empty. reset empties the store
// at once (valid bits and ages cleared) and sets max_entries to 16.
`default_nettype none

module lru_key_value_cache #(
  parameter int unsigned CAPACITY    = lru_kv_pkg::Capacity,
  parameter int unsigned KEY_WIDTH   = lru_kv_pkg::KeyWidth,
  parameter int unsigned VALUE_WIDTH = lru_kv_pkg::ValueWidth
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // configuration
  input  wire logic                              max_entries_we_i,
  input  wire logic [lru_kv_pkg::CfgWidth-1:0]   max_entries_i,
  // request channel
  input  wire logic                              in_valid_i,
  output      logic                              in_ready_o,
  input  wire logic [1:0]                        opcode_i,
  input  wire logic [KEY_WIDTH-1:0]              req_key_i,
  input  wire logic [VALUE_WIDTH-1:0]            req_value_i,
  // result channel
  output      logic                              out_valid_o,
  input  wire logic                              out_ready_i,
  output      logic                              hit_o,
  output      logic [VALUE_WIDTH-1:0]            read_value_o,
  output      logic                              evicted_o,
  output      logic [KEY_WIDTH-1:0]              evicted_key_o,
  output      logic [lru_kv_pkg::CountWidth-1:0] entry_count_o
);

  localparam int unsigned AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW   = $clog2(CAPACITY + 1);
  localparam int unsigned CMPW = (CW > lru_kv_pkg::CfgWidth) ? CW : lru_kv_pkg::CfgWidth;

  // configuration register
  logic [lru_kv_pkg::CfgWidth-1:0] max_entries_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_entries_q <= lru_kv_pkg::MaxEntriesReset;
    end else if (max_entries_we_i) begin
      max_entries_q <= max_entries_i;
    end
  end

  // request register
  logic                   req_valid_q;
  lru_kv_pkg::op_e        req_op_q;
  logic [KEY_WIDTH-1:0]   req_key_q;
  logic [VALUE_WIDTH-1:0] req_value_q;
  logic                   out_valid_q;
  logic                   advance;
  logic                   do_step;

  assign advance    = !out_valid_q || out_ready_i;
  assign do_step    = req_valid_q && advance;
  assign in_ready_o = !req_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      req_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      req_op_q    <= lru_kv_pkg::op_e'(opcode_i);
      req_key_q   <= req_key_i;
      req_value_q <= req_value_i;
    end
  end

  // slot storage
  logic [KEY_WIDTH-1:0]   key_q   [CAPACITY];
  logic [VALUE_WIDTH-1:0] value_q [CAPACITY];
  logic [CAPACITY-1:0]    valid_q;
  logic [AW-1:0]          age_q   [CAPACITY];
  logic [CW-1:0]          count_q;

  // parallel compare, victim and free slot search
  logic [CAPACITY-1:0]    match;
  logic [CAPACITY-1:0]    victim_oh;
  logic [CAPACITY-1:0]    free_oh;
  logic [VALUE_WIDTH-1:0] hit_value;
  logic [KEY_WIDTH-1:0]   victim_key;
  logic [AW-1:0]          hit_age;
  logic [AW-1:0]          oldest_age;

  assign oldest_age = AW'(count_q - CW'(1));

  always_comb begin
    logic seen;
    match      = '0;
    victim_oh  = '0;
    free_oh    = '0;
    hit_value  = '0;
    victim_key = '0;
    hit_age    = '0;
    seen       = 1'b0;
    for (int i = 0; i < CAPACITY; i++) begin
      match[i]     = valid_q[i] && (key_q[i] == req_key_q);
      victim_oh[i] = valid_q[i] && (age_q[i] == oldest_age);
      if (match[i]) begin
        hit_value = hit_value | value_q[i];
        hit_age   = hit_age | age_q[i];
      end
      if (victim_oh[i]) begin
        victim_key = victim_key | key_q[i];
      end
      if (!valid_q[i] && !seen) begin
        free_oh[i] = 1'b1;
        seen       = 1'b1;
      end
    end
  end

  // request decode
  logic                   hit;
  logic                   create;
  logic                   evict;
  logic                   touch;
  logic                   is_insert;
  logic [CMPW-1:0]        limit;
  logic [CAPACITY-1:0]    slot_oh;
  logic [VALUE_WIDTH-1:0] new_value;
  logic [VALUE_WIDTH-1:0] read_value;

  always_comb begin
    logic [CMPW-1:0] m;
    m = CMPW'(max_entries_q);
    if (m == '0) begin
      limit = CMPW'(1);
    end else if (m > CMPW'(CAPACITY)) begin
      limit = CMPW'(CAPACITY);
    end else begin
      limit = m;
    end
  end

  assign hit        = |match;
  assign is_insert  = (req_op_q == lru_kv_pkg::OP_INSERT);
  assign create     = !hit && (is_insert || (req_op_q == lru_kv_pkg::OP_ACCESS));
  assign evict      = create && (CMPW'(count_q) >= limit);
  assign touch      = hit && (req_op_q != lru_kv_pkg::OP_PEEK);
  assign slot_oh    = evict ? victim_oh : free_oh;
  assign new_value  = is_insert ? req_value_q : '0;
  assign read_value = is_insert ? req_value_q : (hit ? hit_value : '0);

  // next valid bits and ages
  logic [CAPACITY-1:0] valid_d;
  logic [AW-1:0]       age_d [CAPACITY];
  logic [CW-1:0]       count_d;

  always_comb begin
    valid_d = valid_q;
    count_d = count_q;
    for (int i = 0; i < CAPACITY; i++) begin
      age_d[i] = age_q[i];
    end
    if (do_step && create) begin
      valid_d = valid_q | slot_oh;
      if (!evict) begin
        count_d = count_q + CW'(1);
      end
      for (int i = 0; i < CAPACITY; i++) begin
        if (slot_oh[i]) begin
          age_d[i] = '0;
        end else if (valid_q[i]) begin
          age_d[i] = age_q[i] + AW'(1);
        end
      end
    end else if (do_step && touch) begin
      for (int i = 0; i < CAPACITY; i++) begin
        if (match[i]) begin
          age_d[i] = '0;
        end else if (valid_q[i] && (age_q[i] < hit_age)) begin
          age_d[i] = age_q[i] + AW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      count_q <= '0;
      for (int i = 0; i < CAPACITY; i++) begin
        age_q[i] <= '0;
      end
    end else begin
      valid_q <= valid_d;
      count_q <= count_d;
      for (int i = 0; i < CAPACITY; i++) begin
        age_q[i] <= age_d[i];
      end
    end
  end

  // key and value write: new entry, or value overwrite on an insert hit
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < CAPACITY; i++) begin
      if (do_step && create && slot_oh[i]) begin
        key_q[i]   <= req_key_q;
        value_q[i] <= new_value;
      end else if (do_step && is_insert && match[i]) begin
        value_q[i] <= req_value_q;
      end
    end
  end

  // result register
  logic                              hit_q;
  logic [VALUE_WIDTH-1:0]            read_value_q;
  logic                              evicted_q;
  logic [KEY_WIDTH-1:0]              evicted_key_q;
  logic [lru_kv_pkg::CountWidth-1:0] entry_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= req_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_step) begin
      hit_q         <= hit;
      read_value_q  <= read_value;
      evicted_q     <= evict;
      evicted_key_q <= evict ? victim_key : '0;
      entry_count_q <= lru_kv_pkg::CountWidth'(count_d);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign hit_o         = hit_q;
  assign read_value_o  = read_value_q;
  assign evicted_o     = evicted_q;
  assign evicted_key_o = evicted_key_q;
  assign entry_count_o = entry_count_q;

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// self-checking testbench for lru_key_value_cache: random and directed requests,
// a behavioral lru predictor and a scoreboard; depends on lru_kv_pkg and the rtl
module tb;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned NumPhases  = 8;

  typedef struct packed {
    lru_kv_pkg::op_e                   op;
    logic [lru_kv_pkg::KeyWidth-1:0]   key;
    logic [lru_kv_pkg::ValueWidth-1:0] value;
  } lookup_t;

  typedef struct packed {
    logic                              hit;
    logic [lru_kv_pkg::ValueWidth-1:0] value;
    logic                              evicted;
    logic [lru_kv_pkg::KeyWidth-1:0]   evicted_key;
    logic [lru_kv_pkg::CountWidth-1:0] count;
  } reply_t;

  logic                              clk_i;
  logic                              rst_ni;
  logic                              max_entries_we_i;
  logic [lru_kv_pkg::CfgWidth-1:0]   max_entries_i;
  logic                              in_valid_i;
  logic                              in_ready_o;
  logic [1:0]                        opcode_i;
  logic [lru_kv_pkg::KeyWidth-1:0]   req_key_i;
  logic [lru_kv_pkg::ValueWidth-1:0] req_value_i;
  logic                              out_valid_o;
  logic                              out_ready_i;
  logic                              hit_o;
  logic [lru_kv_pkg::ValueWidth-1:0] read_value_o;
  logic                              evicted_o;
  logic [lru_kv_pkg::KeyWidth-1:0]   evicted_key_o;
  logic [lru_kv_pkg::CountWidth-1:0] entry_count_o;

  lru_key_value_cache u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .max_entries_we_i (max_entries_we_i),
    .max_entries_i    (max_entries_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .opcode_i         (opcode_i),
    .req_key_i        (req_key_i),
    .req_value_i      (req_value_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .hit_o            (hit_o),
    .read_value_o     (read_value_o),
    .evicted_o        (evicted_o),
    .evicted_key_o    (evicted_key_o),
    .entry_count_o    (entry_count_o)
  );

  // predictor state: slots, recency ages, count and register copy
  logic [lru_kv_pkg::KeyWidth-1:0]   slot_key  [lru_kv_pkg::Capacity];
  logic [lru_kv_pkg::ValueWidth-1:0] slot_val  [lru_kv_pkg::Capacity];
  bit                                slot_used [lru_kv_pkg::Capacity];
  int unsigned                       slot_age  [lru_kv_pkg::Capacity];
  int unsigned                       used_count;
  logic [lru_kv_pkg::CfgWidth-1:0]   entry_limit_reg;

  lookup_t     lookups_to_send[$];
  reply_t      predicted_replies[$];
  logic [lru_kv_pkg::KeyWidth-1:0] key_pool[$];
  int unsigned lookups_queued;
  int unsigned lookups_taken;
  int unsigned mismatches;
  int unsigned cycles;
  int unsigned gap_pct;
  bit          req_taken;

  // clock
  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  function automatic bit take_gap();
    return $urandom_range(99) < gap_pct;
  endfunction

  // lru behavior: lookup, touch, fill and evict, one reply per request
  function automatic reply_t lru_lookup(lookup_t r);
    reply_t      rep;
    int          found;
    int          victim;
    int unsigned limit;
    int unsigned oldest;
    int unsigned touched_age;
    logic [lru_kv_pkg::ValueWidth-1:0] fill_val;
    rep    = '0;
    found  = -1;
    victim = -1;
    oldest = 0;
    for (int i = 0; i < lru_kv_pkg::Capacity; i++) begin
      if (found < 0 && slot_used[i] && slot_key[i] == r.key) found = i;
    end
    if (found >= 0) begin
      rep.hit = 1'b1;
      if (r.op == lru_kv_pkg::OP_INSERT) slot_val[found] = r.value;
      // a touch makes the entry youngest and ages the younger ones
      if (r.op != lru_kv_pkg::OP_PEEK) begin
        touched_age = slot_age[found];
        for (int i = 0; i < lru_kv_pkg::Capacity; i++) begin
          if (slot_used[i] && slot_age[i] < touched_age) slot_age[i]++;
        end
        slot_age[found] = 0;
      end
      rep.value = slot_val[found];
    end else if (r.op == lru_kv_pkg::OP_INSERT || r.op == lru_kv_pkg::OP_ACCESS) begin
      fill_val = (r.op == lru_kv_pkg::OP_INSERT) ? r.value : '0;
      limit = entry_limit_reg;
      if (limit < 1) limit = 1;
      if (limit > lru_kv_pkg::Capacity) limit = lru_kv_pkg::Capacity;
      // full: drop the oldest entry, exactly one even if the limit was lowered
      if (used_count >= limit) begin
        for (int i = 0; i < lru_kv_pkg::Capacity; i++) begin
          if (slot_used[i] && (victim < 0 || slot_age[i] > oldest)) begin
            victim = i;
            oldest = slot_age[i];
          end
        end
        if (victim >= 0) begin
          rep.evicted     = 1'b1;
          rep.evicted_key = slot_key[victim];
          slot_used[victim] = 1'b0;
          used_count--;
        end
      end
      if (victim < 0) begin
        for (int i = 0; i < lru_kv_pkg::Capacity; i++) begin
          if (victim < 0 && !slot_used[i]) victim = i;
        end
      end
      for (int i = 0; i < lru_kv_pkg::Capacity; i++) begin
        if (slot_used[i]) slot_age[i]++;
      end
      slot_key[victim]  = r.key;
      slot_val[victim]  = fill_val;
      slot_used[victim] = 1'b1;
      slot_age[victim]  = 0;
      used_count++;
      rep.value = fill_val;
    end
    rep.count = lru_kv_pkg::CountWidth'(used_count);
    return rep;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("mismatch at cycle %0d: %s got %h expected %h", cycles, field, got, want);
    mismatches++;
  endtask

  task automatic queue_lookup(lru_kv_pkg::op_e op, logic [lru_kv_pkg::KeyWidth-1:0] key,
                              logic [lru_kv_pkg::ValueWidth-1:0] value);
    lookup_t r;
    r.op    = op;
    r.key   = key;
    r.value = value;
    lookups_to_send.push_back(r);
    lookups_queued++;
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (lookups_taken != lookups_queued || predicted_replies.size() != 0);
  endtask

  // request driver: holds a beat until taken, random gaps between beats
  always @(negedge clk_i) begin
    lookup_t r;
    if (rst_ni) begin
      if (!in_valid_i || req_taken) begin
        if (lookups_to_send.size() != 0 && !take_gap()) begin
          r = lookups_to_send.pop_front();
          in_valid_i  <= 1'b1;
          opcode_i    <= r.op;
          req_key_i   <= r.key;
          req_value_i <= r.value;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_ready_i <= !take_gap();
    end
  end

  // monitor: predict on each request beat, check each result beat
  always @(posedge clk_i) begin
    lookup_t r;
    reply_t  want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (predicted_replies.size() == 0) begin
          report_mismatch("unexpected result beat", 32'(1), 32'(0));
        end else begin
          want = predicted_replies.pop_front();
          if (hit_o !== want.hit) report_mismatch("hit", 32'(hit_o), 32'(want.hit));
          if (read_value_o !== want.value)
            report_mismatch("read_value", read_value_o, want.value);
          if (evicted_o !== want.evicted)
            report_mismatch("evicted", 32'(evicted_o), 32'(want.evicted));
          if (evicted_key_o !== want.evicted_key)
            report_mismatch("evicted_key", evicted_key_o, want.evicted_key);
          if (entry_count_o !== want.count)
            report_mismatch("entry_count", 32'(entry_count_o), 32'(want.count));
        end
      end
      if (in_valid_i && in_ready_o) begin
        r.op    = lru_kv_pkg::op_e'(opcode_i);
        r.key   = req_key_i;
        r.value = req_value_i;
        predicted_replies.push_back(lru_lookup(r));
        lookups_taken++;
      end
      req_taken <= in_valid_i && in_ready_o;
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // stimulus phases: register setting, item count, gap rate
  initial begin
    int          phase_cfg [NumPhases];
    int unsigned phase_len [NumPhases];
    int unsigned phase_gap [NumPhases];
    int unsigned eff;
    logic [lru_kv_pkg::KeyWidth-1:0]   key;
    logic [lru_kv_pkg::ValueWidth-1:0] value;
    phase_cfg = '{-1, 3, 1, 0, 31, 16, 2, 8};
    phase_len = '{120, 100, 80, 80, 150, 150, 80, 140};
    phase_gap = '{36, 36, 36, 36, 0, 36, 36, 36};

    rst_ni           <= 1'b0;
    max_entries_we_i <= 1'b0;
    max_entries_i    <= '0;
    in_valid_i       <= 1'b0;
    opcode_i         <= '0;
    req_key_i        <= '0;
    req_value_i      <= '0;
    out_ready_i      <= 1'b0;
    req_taken        = 1'b0;
    cycles           = 0;
    mismatches       = 0;
    lookups_queued   = 0;
    lookups_taken    = 0;
    gap_pct          = 36;
    used_count       = 0;
    entry_limit_reg  = lru_kv_pkg::MaxEntriesReset;
    for (int i = 0; i < lru_kv_pkg::Capacity; i++) begin
      slot_used[i] = 1'b0;
      slot_age[i]  = 0;
      slot_key[i]  = '0;
      slot_val[i]  = '0;
    end
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: misses on empty store, extremes, each opcode, hit cases, overflow
    queue_lookup(lru_kv_pkg::OP_FIND, 32'h1234_5678, 32'hDEAD_BEEF);
    queue_lookup(lru_kv_pkg::OP_PEEK, 32'h1234_5678, '0);
    queue_lookup(lru_kv_pkg::OP_INSERT, 32'h0000_0000, 32'h0000_0000);
    queue_lookup(lru_kv_pkg::OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_lookup(lru_kv_pkg::OP_FIND, 32'h0000_0000, 32'hFFFF_FFFF);
    queue_lookup(lru_kv_pkg::OP_PEEK, 32'hFFFF_FFFF, '0);
    queue_lookup(lru_kv_pkg::OP_ACCESS, 32'h5A5A_A5A5, 32'hFFFF_FFFF);
    queue_lookup(lru_kv_pkg::OP_ACCESS, 32'h5A5A_A5A5, '0);
    queue_lookup(lru_kv_pkg::OP_INSERT, 32'h0000_0000, 32'hA5A5_5A5A);
    for (int i = 1; i <= 14; i++) queue_lookup(lru_kv_pkg::OP_INSERT, 32'(i), ~32'(i));

    for (int p = 0; p < NumPhases; p++) begin
      if (phase_cfg[p] >= 0) begin
        wait_drained();
        repeat (4) @(negedge clk_i);
        max_entries_we_i <= 1'b1;
        max_entries_i    <= lru_kv_pkg::CfgWidth'(phase_cfg[p]);
        entry_limit_reg  = lru_kv_pkg::CfgWidth'(phase_cfg[p]);
        @(negedge clk_i);
        max_entries_we_i <= 1'b0;
      end
      gap_pct = phase_gap[p];
      eff = entry_limit_reg;
      if (eff < 1) eff = 1;
      if (eff > lru_kv_pkg::Capacity) eff = lru_kv_pkg::Capacity;
      // key pool a little larger than the store so hits, misses and evictions mix
      key_pool.delete();
      for (int k = 0; k < eff + 4; k++) key_pool.push_back($urandom);
      for (int n = 0; n < phase_len[p]; n++) begin
        if ($urandom_range(99) < 85) key = key_pool[$urandom_range(key_pool.size() - 1)];
        else key = $urandom;
        case ($urandom_range(9))
          0: value = '0;
          1: value = '1;
          default: value = $urandom;
        endcase
        queue_lookup(lru_kv_pkg::op_e'($urandom_range(3)), key, value);
      end
    end

    wait_drained();
    repeat (8) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
